// ----- rtl/mbe_pkg.sv -----
// Shared types, widths and constants of the escape-time pixel unit.
`default_nettype none

package mbe_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_ITER_DEF  = 65535;
    localparam int FRAC_BITS_DEF = 28;

    localparam int BATCH_W  = 12;
    localparam int ITEM_W   = 24;
    localparam int SHADE_W  = 8;
    localparam int DIM_W    = 13;
    localparam int COORD_W  = 32;
    localparam int STEP_W   = 31;
    localparam int LIM_W    = 16;
    localparam int ROW_W    = 26;
    localparam int PROD_W   = STEP_W + DIM_W;
    localparam int CR_W     = PROD_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_BATCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_START         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_START         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 3'd5;

    localparam logic [DIM_W-1:0]          RST_IMAGE_WIDTH     = 13'd800;
    localparam logic [DIM_W-1:0]          RST_ROWS_PER_BATCH  = 13'd1;
    localparam logic signed [COORD_W-1:0] RST_X_START         = -32'sd570425344;
    localparam logic signed [COORD_W-1:0] RST_Y_START         = -32'sd402653184;
    localparam logic [STEP_W-1:0]         RST_PIXEL_STEP      = 31'd1006633;
    localparam logic [LIM_W-1:0]          RST_ITERATION_LIMIT = 16'd1024;

    localparam logic [SHADE_W-1:0] SHADE_MAX = 8'd255;

    localparam int DIV_N_W = 24;
    localparam int DIV_D_W = 16;

    typedef struct packed {
        logic [BATCH_W-1:0] batch_number;
        logic [ITEM_W-1:0]  work_item;
    } t_in_req;

    typedef struct packed {
        logic [ITEM_W-1:0]  buffer_offset;
        logic [SHADE_W-1:0] shade;
    } t_out_rsp;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT,
        S_ROW,
        S_CHECK,
        S_SEED,
        S_SQ_A,
        S_SQ_B,
        S_MUL_AB,
        S_UPDATE,
        S_SHADE,
        S_SCALE,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/mbe_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module mbe_div import mbe_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_div;

    logic [DIV_D_W:0]   sh;
    logic [DIV_D_W:0]   diff;
    logic               ge;
    logic [DIV_D_W-1:0] n_rem;

    always_comb begin
        sh    = {r_rem, r_quo[DIV_N_W-1]};
        diff  = sh - {1'b0, r_div};
        ge    = (sh >= {1'b0, r_div});
        n_rem = ge ? diff[DIV_D_W-1:0] : sh[DIV_D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// ----- rtl/mbe_fxmul.sv -----
// Shared fixed-point multiplier: registered magnitude product, floor rounding.
`default_nettype none

module mbe_fxmul import mbe_pkg::*; #(
    parameter  int FRACTION_BITS = FRAC_BITS_DEF,
    parameter  int A_W           = CR_W + 1,
    localparam int PR_W          = FRACTION_BITS + 6
) (
    input  wire logic                   i_clk,
    input  wire logic signed [A_W-1:0]  i_x,
    input  wire logic signed [A_W-1:0]  i_y,
    output logic signed [PR_W-1:0]      o_p
);

    localparam int MAG_W = FRACTION_BITS + 2;
    localparam int Q_W   = 2 * MAG_W - FRACTION_BITS;

    logic [A_W-1:0]     abs_x;
    logic [A_W-1:0]     abs_y;
    logic [2*MAG_W-1:0] r_prod;
    logic               r_neg;
    logic [Q_W-1:0]     quo;
    logic               rem_nz;
    logic [PR_W-1:0]    mag_p;

    assign abs_x = i_x[A_W-1] ? (~i_x) + {{(A_W-1){1'b0}}, 1'b1} : i_x;
    assign abs_y = i_y[A_W-1] ? (~i_y) + {{(A_W-1){1'b0}}, 1'b1} : i_y;

    always_ff @(posedge i_clk) begin
        r_prod <= abs_x[MAG_W-1:0] * abs_y[MAG_W-1:0];
        r_neg  <= i_x[A_W-1] ^ i_y[A_W-1];
    end

    assign quo    = r_prod[2*MAG_W-1:FRACTION_BITS];
    assign rem_nz = |r_prod[FRACTION_BITS-1:0];
    assign mag_p  = {2'b00, quo} + {{(PR_W-1){1'b0}}, rem_nz & r_neg};
    assign o_p    = r_neg ? $signed(~mag_p + PR_W'(1)) : $signed(mag_p);

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_pixel_unit.sv -----
// Escape-time pixel unit: one request at a time through a shared multiplier and divider.
// A request runs the item split in the divider, the row and column products, the drop
// check, loop passes (a*a, b*b, a*b, update), then the shade scaling in the divider;
// with no completed update the scaling is skipped. Reset restores idle and the defaults.
// Throughput: one request per result, the next taken the cycle after the result is taken;
// a dropped request frees the unit after the drop check, or at once for a zero image size.
`default_nettype none

module mandelbrot_escape_pixel_unit import mbe_pkg::*; #(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int MAX_ITERATIONS = MAX_ITER_DEF,
    parameter int FRACTION_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_in_req               i_req,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out_rsp                   o_rsp
);

    localparam int PR_W  = FRACTION_BITS + 6;
    localparam int SUM_W = PR_W + 1;
    localparam int A_W   = ((CR_W > FRACTION_BITS + 7) ? CR_W : FRACTION_BITS + 7) + 1;

    localparam logic signed [SUM_W-1:0] FOUR    = SUM_W'(4) <<< FRACTION_BITS;
    localparam logic signed [A_W-1:0]   BIG_POS = A_W'(1) <<< (FRACTION_BITS + 2);
    localparam logic signed [A_W-1:0]   BIG_NEG = -BIG_POS;

    logic [DIM_W-1:0]          r_image_width;
    logic [DIM_W-1:0]          r_rows_per_batch;
    logic signed [COORD_W-1:0] r_x_start;
    logic signed [COORD_W-1:0] r_y_start;
    logic [STEP_W-1:0]         r_pixel_step;
    logic [LIM_W-1:0]          r_iteration_limit;

    t_state r_state, n_state;

    logic [BATCH_W-1:0]     r_batch, n_batch;
    logic [ITEM_W-1:0]      r_item, n_item;
    logic [ITEM_W-1:0]      r_rib, n_rib;
    logic [DIM_W-1:0]       r_col, n_col;
    logic [ROW_W-1:0]       r_row, n_row;
    logic [PROD_W-1:0]      r_pc, n_pc;
    logic [PROD_W-1:0]      r_pr, n_pr;
    logic signed [CR_W-1:0] r_cr, n_cr;
    logic signed [CR_W-1:0] r_ci, n_ci;
    logic signed [A_W-1:0]  r_a, n_a;
    logic signed [A_W-1:0]  r_b, n_b;
    logic signed [PR_W-1:0] r_a2, n_a2;
    logic signed [PR_W-1:0] r_b2, n_b2;
    logic [LIM_W-1:0]       r_k, n_k;
    logic [SHADE_W-1:0]     r_shade, n_shade;

    logic [DIM_W-1:0]        eff_width;
    logic [DIM_W-1:0]        eff_rows;
    logic [LIM_W-1:0]        eff_lim;
    logic                    dims_ok;
    logic                    drop;
    logic signed [CR_W-1:0]  ci_sum;
    logic signed [SUM_W-1:0] sq_sum;
    logic                    big_a;
    logic                    big_b;
    logic                    escape;
    logic                    iter_last;

    t_div_req               div_req;
    t_div_rsp               div_rsp;
    logic signed [A_W-1:0]  mul_x;
    logic signed [A_W-1:0]  mul_y;
    logic signed [PR_W-1:0] mul_p;

    mbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    mbe_fxmul #(
        .FRACTION_BITS (FRACTION_BITS),
        .A_W           (A_W)
    ) u_fxmul (
        .i_clk (i_clk),
        .i_x   (mul_x),
        .i_y   (mul_y),
        .o_p   (mul_p)
    );

    always_comb begin
        eff_width = ({19'd0, r_image_width} > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                              : r_image_width;
        eff_rows  = ({19'd0, r_rows_per_batch} > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                                 : r_rows_per_batch;
        eff_lim   = ({16'd0, r_iteration_limit} > 32'(MAX_ITERATIONS))
                    ? LIM_W'(MAX_ITERATIONS) : r_iteration_limit;
        dims_ok   = (eff_width != '0) && (eff_rows != '0);
        drop      = (r_row >= ROW_W'(eff_width)) || (r_rib >= ITEM_W'(eff_rows));
        ci_sum    = CR_W'(r_y_start) + $signed(CR_W'(r_pr));
        sq_sum    = SUM_W'(r_a2) + SUM_W'(r_b2);
        big_a     = (r_a >= BIG_POS) || (r_a <= BIG_NEG);
        big_b     = (r_b >= BIG_POS) || (r_b <= BIG_NEG);
        escape    = big_a || big_b || (sq_sum > FOUR);
        iter_last = ((r_k + LIM_W'(1)) == eff_lim);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && dims_ok) begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (div_rsp.done) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = drop ? S_IDLE : S_SEED;
            end
            S_SEED: begin
                n_state = (eff_lim == '0) ? S_SHADE : S_SQ_A;
            end
            S_SQ_A: begin
                n_state = S_SQ_B;
            end
            S_SQ_B: begin
                n_state = S_MUL_AB;
            end
            S_MUL_AB: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = (escape || iter_last) ? S_SHADE : S_SQ_A;
            end
            S_SHADE: begin
                n_state = (r_k == '0) ? S_OUT : S_SCALE;
            end
            S_SCALE: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready          = (r_state == S_IDLE);
        o_valid          = (r_state == S_OUT);
        div_req.start    = 1'b0;
        div_req.dividend = {r_k, 8'd0} - DIV_N_W'(r_k);
        div_req.divisor  = eff_lim;
        mul_x            = r_a;
        mul_y            = r_a;
        case (r_state)
            S_IDLE: begin
                div_req.start    = i_valid && dims_ok;
                div_req.dividend = i_req.work_item;
                div_req.divisor  = DIV_D_W'(eff_width);
            end
            S_SQ_B: begin
                mul_x = r_b;
                mul_y = r_b;
            end
            S_MUL_AB: begin
                mul_y = r_b;
            end
            S_SHADE: begin
                div_req.start = (r_k != '0);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_batch = r_batch;
        n_item  = r_item;
        n_rib   = r_rib;
        n_col   = r_col;
        n_row   = r_row;
        n_pc    = r_pc;
        n_pr    = r_pr;
        n_cr    = r_cr;
        n_ci    = r_ci;
        n_a     = r_a;
        n_b     = r_b;
        n_a2    = r_a2;
        n_b2    = r_b2;
        n_k     = r_k;
        n_shade = r_shade;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_batch = i_req.batch_number;
                    n_item  = i_req.work_item;
                end
            end
            S_SPLIT: begin
                if (div_rsp.done) begin
                    n_rib = div_rsp.quotient;
                    n_col = div_rsp.remainder[DIM_W-1:0];
                end
            end
            S_ROW: begin
                n_row = ROW_W'(r_batch) * ROW_W'(eff_rows) + ROW_W'(r_rib);
                n_pc  = PROD_W'(r_pixel_step) * PROD_W'(r_col);
            end
            S_CHECK: begin
                n_cr = CR_W'(r_x_start) + $signed(CR_W'(r_pc));
                n_pr = PROD_W'(r_pixel_step) * PROD_W'(r_row[DIM_W-1:0]);
            end
            S_SEED: begin
                n_ci = ci_sum;
                n_a  = A_W'(r_cr);
                n_b  = A_W'(ci_sum);
                n_k  = '0;
            end
            S_SQ_B: begin
                n_a2 = mul_p;
            end
            S_MUL_AB: begin
                n_b2 = mul_p;
            end
            S_UPDATE: begin
                if (!escape) begin
                    n_a = A_W'(r_a2) - A_W'(r_b2) + A_W'(r_cr);
                    n_b = (A_W'(mul_p) <<< 1) + A_W'(r_ci);
                    n_k = r_k + LIM_W'(1);
                end
            end
            S_SHADE: begin
                if (r_k == '0) begin
                    n_shade = SHADE_MAX;
                end
            end
            S_SCALE: begin
                if (div_rsp.done) begin
                    n_shade = SHADE_W'(DIV_N_W'(SHADE_MAX) - div_rsp.quotient);
                end
            end
            default: begin
                n_shade = r_shade;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_image_width     <= RST_IMAGE_WIDTH;
            r_rows_per_batch  <= RST_ROWS_PER_BATCH;
            r_x_start         <= RST_X_START;
            r_y_start         <= RST_Y_START;
            r_pixel_step      <= RST_PIXEL_STEP;
            r_iteration_limit <= RST_ITERATION_LIMIT;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[DIM_W-1:0];
                    CFG_ROWS_PER_BATCH:  r_rows_per_batch  <= i_cfg_data[DIM_W-1:0];
                    CFG_X_START:         r_x_start         <= i_cfg_data[COORD_W-1:0];
                    CFG_Y_START:         r_y_start         <= i_cfg_data[COORD_W-1:0];
                    CFG_PIXEL_STEP:      r_pixel_step      <= i_cfg_data[STEP_W-1:0];
                    CFG_ITERATION_LIMIT: r_iteration_limit <= i_cfg_data[LIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_batch <= n_batch;
        r_item  <= n_item;
        r_rib   <= n_rib;
        r_col   <= n_col;
        r_row   <= n_row;
        r_pc    <= n_pc;
        r_pr    <= n_pr;
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_a     <= n_a;
        r_b     <= n_b;
        r_a2    <= n_a2;
        r_b2    <= n_b2;
        r_k     <= n_k;
        r_shade <= n_shade;
    end

    assign o_rsp.buffer_offset = r_item;
    assign o_rsp.shade         = r_shade;

endmodule

`default_nettype wire
